// ----- design/swmmm_pkg.sv -----
// shared types, widths and constants of the sliding window min/max/mean block
package swmmm_pkg;

    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_CHANNELS     = 4;

    localparam int DATA_W   = 32;
    localparam int CH_IN_W  = 2;
    localparam int WLEN_W   = 7;
    localparam int HEIGHT_W = 12;
    localparam int FILL_W   = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // window sum: at most 127 samples of 32 bits
    localparam int SUM_W  = DATA_W + WLEN_W;
    localparam int SPAN_W = DATA_W + 1;
    localparam int PROD_W = SPAN_W + HEIGHT_W;

    // serial divider
    localparam int DVD_W      = PROD_W + 1;
    localparam int DVS_W      = SPAN_W;
    localparam int STEP_W     = 6;
    localparam int MEAN_STEPS = SUM_W - 1;
    localparam int PLOT_STEPS = HEIGHT_W + 1;

    localparam logic [WLEN_W-1:0]   WLEN_RST   = 7'd64;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd200;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_PLOT_HEIGHT   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

endpackage

// ----- design/swmmm_ram.sv -----
// generic single-port-write, registered-read RAM
module swmmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/swmmm_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module swmmm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swmmm_pkg::div_cmd_t          cmd,
    input  logic [swmmm_pkg::DVS_W-1:0]  rem_init,
    input  logic [swmmm_pkg::DVD_W-1:0]  quo_init,
    input  logic [swmmm_pkg::DVS_W-1:0]  divisor,
    output logic [swmmm_pkg::DVD_W-1:0]  quotient,
    output logic                         done
);

    import swmmm_pkg::*;

    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  sh_reg, sh_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              qbit;

    // remainder shifted left with the next dividend bit coming in from the top
    assign trial = {rem_reg, sh_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next  = rem_init;
            sh_next   = quo_init;
            dvs_next  = divisor;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            sh_next  = {sh_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

endmodule

// ----- design/sliding_window_min_max_mean.sv -----
// top level: per-channel sliding window min, max, mean and plot row
// Each word brings a channel and a signed Q16.16 sample. The sample is written into that
// channel's window in the cycle it is accepted; the window is then read back one entry per
// cycle through the single RAM read port while min, max and sum build up, the mean is
// formed by a bit-serial divider (38 steps) and, unless the window is flat or the plot
// height is zero, the plot row by a second pass through the same divider (13 steps).
// in_ready is low from acceptance until the result is loaded into the output register, and
// stays low while the previous result still sits unread in the output register. A finished
// result waits in the output register, so the next word may be accepted before it is taken.
// Writing window_length empties all channel windows.
module sliding_window_min_max_mean #(
    parameter int WINDOW_DEPTH = swmmm_pkg::DEF_WINDOW_DEPTH,
    parameter int CHANNELS     = swmmm_pkg::DEF_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swmmm_pkg::PADDR_W-1:0]     paddr,
    input  logic [swmmm_pkg::PDATA_W-1:0]     pwdata,
    output logic [swmmm_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swmmm_pkg::CH_IN_W-1:0]     channel,
    input  logic signed [swmmm_pkg::DATA_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [swmmm_pkg::DATA_W-1:0] window_min,
    output logic signed [swmmm_pkg::DATA_W-1:0] window_max,
    output logic signed [swmmm_pkg::DATA_W-1:0] window_mean,
    output logic [swmmm_pkg::FILL_W-1:0]      fill_count,
    output logic [swmmm_pkg::HEIGHT_W-1:0]    plot_row
);

    import swmmm_pkg::*;

    localparam int IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int LEN_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_DEPTH = CHANNELS * (2 ** IDX_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MSTART = 3'd2;
    localparam logic [2:0] ST_MEAN   = 3'd3;
    localparam logic [2:0] ST_PLOT   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    function automatic logic [CH_W-1:0] wrap_ch(input logic [CH_IN_W-1:0] c);
        int v;
        v = int'(c);
        for (int k = 0; k < 3; k++)
        begin
            if (v >= CHANNELS)
            begin
                v = v - CHANNELS;
            end
        end
        return CH_W'(v);
    endfunction

    // configuration
    logic [WLEN_W-1:0]   wlen_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_wr;
    logic                wlen_wr;

    assign cfg_wr  = psel && penable && pwrite;
    assign wlen_wr = cfg_wr && (paddr[2] == REG_WINDOW_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_PLOT_HEIGHT) ? PDATA_W'(height_reg)
                                                   : PDATA_W'(wlen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= WLEN_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_LENGTH: wlen_reg   <= pwdata[WLEN_W-1:0];
                REG_PLOT_HEIGHT:   height_reg <= pwdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(wlen_reg) > WINDOW_DEPTH)
        begin
            len = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            len = LEN_W'(wlen_reg);
        end
    end

    // sequencer state
    logic [2:0]       state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] wp_reg   [CHANNELS];
    logic [LEN_W-1:0] fcnt_reg [CHANNELS];

    logic             accept;
    logic [CH_W-1:0]  ch_in;
    logic [LEN_W-1:0] wp_ext, wp_eff, wp_inc, wp_new;
    logic [LEN_W-1:0] fill_cur, fill_new;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign ch_in    = wrap_ch(channel);

    always_comb
    begin
        wp_ext   = LEN_W'(wp_reg[ch_in]);
        wp_eff   = (wp_ext >= len) ? '0 : wp_ext;
        wp_inc   = wp_eff + LEN_W'(1);
        wp_new   = (wp_inc >= len) ? '0 : wp_inc;
        fill_cur = fcnt_reg[ch_in];
        fill_new = (fill_cur < len) ? fill_cur + LEN_W'(1) : len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                fcnt_reg[c] <= '0;
            end
        end
        else if (wlen_wr)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                fcnt_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            wp_reg[ch_in]   <= wp_new[IDX_W-1:0];
            fcnt_reg[ch_in] <= fill_new;
        end
    end

    // window store
    logic                     ram_re;
    logic [RAM_AW-1:0]        ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;

    // per-item working registers
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic signed [DATA_W-1:0] s_reg, s_next;
    logic [LEN_W-1:0]         fill_reg, fill_next;
    logic [LEN_W-1:0]         idx_reg, idx_next;
    logic signed [DATA_W-1:0] lo_reg, lo_next;
    logic signed [DATA_W-1:0] hi_reg, hi_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SPAN_W-1:0]        span_reg, span_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     flat_reg, flat_next;
    logic signed [DATA_W-1:0] mean_reg, mean_next;
    logic [HEIGHT_W-1:0]      row_reg, row_next;

    logic signed [DATA_W-1:0] min_out_reg, min_out_next;
    logic signed [DATA_W-1:0] max_out_reg, max_out_next;
    logic signed [DATA_W-1:0] mean_out_reg, mean_out_next;
    logic [FILL_W-1:0]        fill_out_reg, fill_out_next;
    logic [HEIGHT_W-1:0]      row_out_reg, row_out_next;

    assign ram_waddr = RAM_AW'({ch_in, wp_eff[IDX_W-1:0]});
    assign ram_raddr = RAM_AW'({ch_reg, idx_reg[IDX_W-1:0]});
    assign ram_re    = (state_reg == ST_SCAN) && (idx_reg < fill_reg);

    swmmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (ram_waddr),
        .wdata (sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider
    div_cmd_t          div_cmd;
    logic [DVS_W-1:0]  div_rem_init;
    logic [DVD_W-1:0]  div_quo_init;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_q;
    logic              div_done;

    swmmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .quo_init (div_quo_init),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    logic                sum_neg;
    logic [SUM_W-1:0]    sum_mag;
    logic [DATA_W-1:0]   q_mean;
    logic [SPAN_W-1:0]   off;
    logic                out_load;

    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_mean  = div_q[DATA_W-1:0];
    assign off     = SPAN_W'(s_reg) - SPAN_W'(lo_reg);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ch_next        = ch_reg;
        s_next         = s_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        span_next      = span_reg;
        prod_next      = prod_reg;
        flat_next      = flat_reg;
        mean_next      = mean_reg;
        row_next       = row_reg;
        min_out_next   = min_out_reg;
        max_out_next   = max_out_reg;
        mean_out_next  = mean_out_reg;
        fill_out_next  = fill_out_reg;
        row_out_next   = row_out_reg;
        div_cmd        = '{start: 1'b0, steps: '0};
        div_rem_init   = '0;
        div_quo_init   = '0;
        div_divisor    = '0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = ch_in;
                    s_next     = sample;
                    fill_next  = fill_new;
                    idx_next   = '0;
                    lo_next    = sample;
                    hi_next    = sample;
                    sum_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read data arrives in the cycle after its address
                if (idx_reg != '0)
                begin
                    if (ram_rdata < lo_reg)
                    begin
                        lo_next = ram_rdata;
                    end
                    if (ram_rdata > hi_reg)
                    begin
                        hi_next = ram_rdata;
                    end
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                end
                idx_next = idx_reg + LEN_W'(1);
                if (idx_reg == fill_reg)
                begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART:
            begin
                span_next      = SPAN_W'(hi_reg) - SPAN_W'(lo_reg);
                prod_next      = PROD_W'(off) * PROD_W'(height_reg);
                flat_next      = (lo_reg == hi_reg) || (height_reg == '0);
                div_cmd        = '{start: 1'b1, steps: STEP_W'(MEAN_STEPS)};
                div_rem_init   = '0;
                div_quo_init   = DVD_W'(sum_mag) << (DVD_W - MEAN_STEPS);
                div_divisor    = DVS_W'(fill_reg);
                state_next     = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_next = sum_neg ? DATA_W'(-q_mean) : DATA_W'(q_mean);
                    if (flat_reg)
                    begin
                        row_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_cmd      = '{start: 1'b1, steps: STEP_W'(PLOT_STEPS)};
                        div_rem_init = DVS_W'(prod_reg >> PLOT_STEPS);
                        div_quo_init = DVD_W'(prod_reg) << (DVD_W - PLOT_STEPS);
                        div_divisor  = span_reg;
                        state_next   = ST_PLOT;
                    end
                end
            end
            ST_PLOT:
            begin
                if (div_done)
                begin
                    row_next   = height_reg - div_q[HEIGHT_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            min_out_next   = lo_reg;
            max_out_next   = hi_reg;
            mean_out_next  = mean_reg;
            fill_out_next  = FILL_W'(fill_reg);
            row_out_next   = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        s_reg        <= s_next;
        fill_reg     <= fill_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        sum_reg      <= sum_next;
        span_reg     <= span_next;
        prod_reg     <= prod_next;
        flat_reg     <= flat_next;
        mean_reg     <= mean_next;
        row_reg      <= row_next;
        min_out_reg  <= min_out_next;
        max_out_reg  <= max_out_next;
        mean_out_reg <= mean_out_next;
        fill_out_reg <= fill_out_next;
        row_out_reg  <= row_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign window_min  = min_out_reg;
    assign window_max  = max_out_reg;
    assign window_mean = mean_out_reg;
    assign fill_count  = fill_out_reg;
    assign plot_row    = row_out_reg;

endmodule

// ----- sim/swmmm_stats_checker.sv -----
// checker for the sliding window block: tracks config, predicts window stats, compares words
`timescale 1ns / 1ps

module swmmm_stats_checker #(
    parameter int WINDOW_DEPTH = swmmm_pkg::DEF_WINDOW_DEPTH,
    parameter int CHANNELS     = swmmm_pkg::DEF_CHANNELS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [swmmm_pkg::PADDR_W-1:0]         paddr,
    input  logic [swmmm_pkg::PDATA_W-1:0]         pwdata,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [swmmm_pkg::CH_IN_W-1:0]         channel,
    input  logic signed [swmmm_pkg::DATA_W-1:0]   sample,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [swmmm_pkg::DATA_W-1:0]   window_min,
    input  logic signed [swmmm_pkg::DATA_W-1:0]   window_max,
    input  logic signed [swmmm_pkg::DATA_W-1:0]   window_mean,
    input  logic [swmmm_pkg::FILL_W-1:0]          fill_count,
    input  logic [swmmm_pkg::HEIGHT_W-1:0]        plot_row,
    output int                                    fail_count,
    output int                                    pending_stats
);

    import swmmm_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] smallest;
        logic signed [DATA_W-1:0] largest;
        logic signed [DATA_W-1:0] mean;
        logic [FILL_W-1:0]        fill;
        logic [HEIGHT_W-1:0]      row;
    } window_stats_t;

    logic signed [DATA_W-1:0] win_store [CHANNELS][WINDOW_DEPTH];
    int unsigned              win_fill  [CHANNELS];
    int unsigned              win_ptr   [CHANNELS];
    logic [WLEN_W-1:0]        cfg_wlen;
    logic [HEIGHT_W-1:0]      cfg_height;
    window_stats_t            expected_stats [$];

    function automatic window_stats_t advance_window(input int ch,
                                                     input logic signed [DATA_W-1:0] s);
        window_stats_t r;
        int unsigned   len;
        int unsigned   ptr;
        longint        total;
        longint        lo;
        longint        hi;
        longint        v;
        longint        span;
        longint        offset;
        len = (cfg_wlen == 0) ? 1 : (cfg_wlen > WINDOW_DEPTH) ? WINDOW_DEPTH : cfg_wlen;
        ptr = win_ptr[ch];
        if (ptr >= len)
            ptr = 0;
        win_store[ch][ptr] = s;
        ptr++;
        if (ptr >= len)
            ptr = 0;
        win_ptr[ch] = ptr;
        if (win_fill[ch] < len)
            win_fill[ch]++;
        else
            win_fill[ch] = len;

        // window always sits in slots 0..fill-1, pointers restart at zero on clear
        lo    = longint'(s);
        hi    = longint'(s);
        total = 0;
        for (int i = 0; i < win_fill[ch]; i++)
        begin
            v = longint'(win_store[ch][i]);
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
            total += v;
        end

        r.smallest = DATA_W'(lo);
        r.largest  = DATA_W'(hi);
        r.mean     = DATA_W'(total / longint'(win_fill[ch]));
        r.fill     = FILL_W'(win_fill[ch]);
        r.row      = '0;
        if (lo != hi && cfg_height != 0)
        begin
            span   = hi - lo;
            offset = longint'(s) - lo;
            r.row  = cfg_height - HEIGHT_W'((offset * longint'(cfg_height)) / span);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t want;
        if (!rst_n)
        begin
            cfg_wlen   = WLEN_RST;
            cfg_height = HEIGHT_RST;
            for (int c = 0; c < CHANNELS; c++)
            begin
                win_fill[c] = 0;
                win_ptr[c]  = 0;
            end
            expected_stats.delete();
            pending_stats = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH)
                begin
                    cfg_wlen = pwdata[WLEN_W-1:0];
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        win_fill[c] = 0;
                        win_ptr[c]  = 0;
                    end
                end
                else if (paddr[PADDR_W-1:2] == REG_PLOT_HEIGHT)
                    cfg_height = pwdata[HEIGHT_W-1:0];
            end

            // result side first: a word accepted this edge cannot already be answered
            if (out_valid && out_ready)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("window_min", want.smallest, window_min);
                    check_field("window_max", want.largest, window_max);
                    check_field("window_mean", want.mean, window_mean);
                    check_field("fill_count", want.fill, fill_count);
                    check_field("plot_row", want.row, plot_row);
                end
            end

            if (in_valid && in_ready)
                expected_stats.insert(expected_stats.size(),
                                      advance_window(int'(channel) % CHANNELS, sample));

            pending_stats = expected_stats.size();
        end
    end

endmodule

// ----- sim/sliding_window_min_max_mean_test.sv -----
// testbench top: stimulus, handshake pacing and verdict for the sliding window block
`timescale 1ns / 1ps

module sliding_window_min_max_mean_test;
    import swmmm_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 105;
    localparam int SETTLE_TICKS = 200;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic [CH_IN_W-1:0]       channel;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] window_min;
    logic signed [DATA_W-1:0] window_max;
    logic signed [DATA_W-1:0] window_mean;
    logic [FILL_W-1:0]        fill_count;
    logic [HEIGHT_W-1:0]      plot_row;

    int fail_count;
    int pending_stats;
    int quiet_cycles = 0;
    int out_hold     = 0;
    bit calm_out     = 1'b0;
    bit calm_in      = 1'b0;

    logic signed [DATA_W-1:0] phase_base;
    int                       phase_spread;
    int                       phase_channels;

    int wlen_plan   [PHASES] = '{1, 64, 127, 0, 5, 2, 33, 0};
    int height_plan [PHASES] = '{1, 4095, 200, 0, 17, 4095, 1000, 0};

    sliding_window_min_max_mean dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_min  (window_min),
        .window_max  (window_max),
        .window_mean (window_mean),
        .fill_count  (fill_count),
        .plot_row    (plot_row)
    );

    swmmm_stats_checker stats_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel       (channel),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_min    (window_min),
        .window_max    (window_max),
        .window_mean   (window_mean),
        .fill_count    (fill_count),
        .plot_row      (plot_row),
        .fail_count    (fail_count),
        .pending_stats (pending_stats)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_sample();
        int r;
        int delta;
        r = $urandom_range(0, 9);
        delta = $urandom_range(0, 2 * phase_spread) - phase_spread;
        case (r)
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2, 3, 4, 5: return phase_base + delta;
            6, 7:    return $urandom_range(0, 200 << 16) - (100 << 16);
            default: return phase_base;
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_ready <= 1'b0;
            out_hold  <= out_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm_out && $urandom_range(0, 3) == 0)
                out_hold <= pick_gap();
        end
        if ($urandom_range(0, 399) == 0)
            calm_out <= !calm_out;
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_stats != 0)
            @(negedge clk);
    endtask

    task automatic configure(input int wlen, input int height);
        wait_drained();
        apb_write(REG_WINDOW_LENGTH, PDATA_W'(wlen));
        apb_write(REG_PLOT_HEIGHT, PDATA_W'(height));
    endtask

    // unless it inserts a random gap, leaves valid high on return so a back-to-back word needs no second assignment
    task automatic send_word(input logic [CH_IN_W-1:0] ch, input logic signed [DATA_W-1:0] s);
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!calm_in && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [CH_IN_W-1:0] ch;
        int wlen;
        int height;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        channel   = '0;
        sample    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: extremes, every channel, mean rounding toward zero
        send_word(2'd0, 32'sh7FFF_FFFF);
        send_word(2'd0, 32'sh8000_0000);
        send_word(2'd0, 32'sh0000_0000);
        send_word(2'd1, -32'sd3);
        send_word(2'd1, -32'sd4);
        send_word(2'd2, 32'sh0001_8000);
        send_word(2'd3, 32'shFFFE_8000);
        send_word(2'd3, 32'sh0001_0000);

        // length zero behaves as one
        configure(0, 4095);
        send_word(2'd0, 32'sd5);
        send_word(2'd0, -32'sd5);

        // oversize length clamps to depth, zero height forces row zero
        configure(127, 0);
        send_word(2'd1, 32'sd100);
        send_word(2'd1, -32'sd100);
        send_word(2'd1, 32'sd7);

        // two-deep window wraps and drops the oldest word
        configure(2, 1);
        send_word(2'd2, 32'sd10);
        send_word(2'd2, 32'sd20);
        send_word(2'd2, 32'sd30);
        send_word(2'd2, 32'sd15);

        // height change alone keeps the windows
        wait_drained();
        apb_write(REG_PLOT_HEIGHT, PDATA_W'(4095));
        send_word(2'd3, 32'sh7FFF_FFFF);
        send_word(2'd3, 32'sh8000_0000);
        send_word(2'd3, 32'sh7FFF_FFFF);

        for (int p = 0; p < PHASES; p++)
        begin
            wlen   = (p == PHASES - 1) ? $urandom_range(0, 127) : wlen_plan[p];
            height = (p == PHASES - 1) ? $urandom_range(0, 4095) : height_plan[p];
            configure(wlen, height);
            phase_base     = $urandom;
            phase_spread   = 1 << $urandom_range(0, 20);
            phase_channels = (p == 1) ? 1 : $urandom_range(1, 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                ch = CH_IN_W'($urandom_range(0, phase_channels - 1));
                if ($urandom_range(0, 9) == 0)
                    ch = CH_IN_W'($urandom);
                send_word(ch, rand_sample());
                if ((p == 0 && n == 10) || $urandom_range(0, 39) == 0)
                    wait_drained();
                if ($urandom_range(0, 59) == 0)
                    calm_in = !calm_in;
            end
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
